>>> sv/assert_macros.svh
// Assertion macros used by the button debounce classifier back end (bdpc_back).
// No dependencies; simulation builds get checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/bdpc_pkg.sv
// Shared types, constants and helpers for the button debounce classifier.
// No dependencies; used by every module of the block.
package bdpc_pkg;

  // Block limits and defaults
  localparam int MaxButtons   = 16;
  localparam int NumButtonsDef = 4;
  localparam int MaxEvents    = 8;
  localparam int QueueDepth   = 2;
  localparam int CntW         = 16;
  localparam int DebW         = 10;
  localparam int LongW        = 16;
  localparam int CfgDataW     = 16;
  localparam int CfgIdxW      = 1;
  localparam int NumSlots     = 2 * MaxButtons;
  localparam int SlotW        = $clog2(NumSlots);
  localparam int EvCntW       = $clog2(MaxEvents);

  localparam logic [DebW-1:0]  DebounceRst  = DebW'(50);
  localparam logic [LongW-1:0] LongPressRst = LongW'(1000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_e;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLICK   = 2'd2,
    EV_LONG    = 2'd3
  } event_kind_e;

  // One tick's worth of events: two slots per button, lowest slot first
  typedef struct packed {
    logic [NumSlots-1:0]             pend;
    logic [NumSlots-1:0][1:0]        kind;
    logic [MaxButtons-1:0]           mask;
  } tick_rec_t;

  // Saturating counter increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + CntW'(1);
  endfunction

endpackage

>>> sv/bdpc_front.sv
// Front end: per-button debounce and press classification, one tick per cycle while ticks are accepted.
// Depends on bdpc_pkg; feeds tick records to bdpc_queue.
module bdpc_front #(
  parameter int NumButtons = bdpc_pkg::NumButtonsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,       // tick accepted this cycle
  input  logic [NumButtons-1:0]       pin_levels_i,
  input  logic [bdpc_pkg::DebW-1:0]   debounce_i,
  input  logic [bdpc_pkg::LongW-1:0]  long_press_i,
  output logic                        push_o,
  output bdpc_pkg::tick_rec_t         rec_o
);

  logic [NumButtons-1:0]                     prev_q, prev_d;
  logic [NumButtons-1:0]                     sp_q, sp_d;
  logic [NumButtons-1:0]                     lr_q, lr_d;
  logic [NumButtons-1:0][bdpc_pkg::CntW-1:0] st_q, st_d;
  logic [NumButtons-1:0][bdpc_pkg::CntW-1:0] held_q, held_d;

  // Per-button next state and event slots
  always_comb begin
    logic                      rd;
    logic                      chg;
    logic                      lng;
    logic                      lr_t;
    logic [bdpc_pkg::CntW-1:0] held_t;
    logic [bdpc_pkg::CntW-1:0] st_t;
    rec_o = '0;
    for (int i = 0; i < NumButtons; i++) begin
      rd     = ~pin_levels_i[i];
      held_t = sp_q[i] ? bdpc_pkg::sat_inc(held_q[i]) : held_q[i];
      st_t   = (rd != prev_q[i]) ? '0 : bdpc_pkg::sat_inc(st_q[i]);
      chg    = (st_t > bdpc_pkg::CntW'(debounce_i)) && (rd != sp_q[i]);
      lr_t   = lr_q[i];
      if (chg && rd) begin
        held_t = '0;
        lr_t   = 1'b0;
      end
      sp_d[i]   = chg ? rd : sp_q[i];
      lng       = sp_d[i] && !lr_t && (held_t >= long_press_i);
      lr_d[i]   = lng | lr_t;
      prev_d[i] = rd;
      st_d[i]   = st_t;
      held_d[i] = held_t;
      // first slot: press/release, or a lone long press
      rec_o.pend[2*i]     = chg | lng;
      rec_o.kind[2*i]     = chg ? (rd ? bdpc_pkg::EV_PRESS : bdpc_pkg::EV_RELEASE)
                                : bdpc_pkg::EV_LONG;
      // second slot: long press right after press, or click after release
      rec_o.pend[2*i+1]   = chg && (rd ? lng : !lr_q[i]);
      rec_o.kind[2*i+1]   = rd ? bdpc_pkg::EV_LONG : bdpc_pkg::EV_CLICK;
      rec_o.mask[i]       = sp_d[i];
    end
  end

  assign push_o = tick_i && (rec_o.pend != '0);

  // Button state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sp_q   <= '0;
      lr_q   <= '0;
      st_q   <= '1;
      held_q <= '0;
    end else if (tick_i) begin
      prev_q <= prev_d;
      sp_q   <= sp_d;
      lr_q   <= lr_d;
      st_q   <= st_d;
      held_q <= held_d;
    end
  end

endmodule

>>> sv/bdpc_queue.sv
// Short queue of tick records between the front end and the event drain.
// Depends on bdpc_pkg.
module bdpc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bdpc_pkg::tick_rec_t rec_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output bdpc_pkg::tick_rec_t rec_o
);

  localparam int PtrW = (bdpc_pkg::QueueDepth > 1) ? $clog2(bdpc_pkg::QueueDepth) : 1;
  localparam int CntQW = $clog2(bdpc_pkg::QueueDepth + 1);

  bdpc_pkg::tick_rec_t mem_q [bdpc_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntQW'(bdpc_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(bdpc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(bdpc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntQW'(1);
      2'b01:   cnt_d = cnt_q - CntQW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

>>> sv/bdpc_back.sv
// Back end: drains one tick record into single events, one per cycle unless the output stalls.
// Depends on bdpc_pkg and assert_macros.svh; reads from bdpc_queue.
`include "assert_macros.svh"
module bdpc_back #(
  parameter int NumButtons = bdpc_pkg::NumButtonsDef,
  parameter int IdxW       = (NumButtons > 1) ? $clog2(NumButtons) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  bdpc_pkg::tick_rec_t   rec_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [IdxW-1:0]       button_index_o,
  output logic [1:0]            event_kind_o,
  output logic [NumButtons-1:0] pressed_mask_o,
  output logic                  last_event_o
);

  logic                            busy_q, busy_d;
  logic [bdpc_pkg::NumSlots-1:0]   pend_q, pend_d;
  bdpc_pkg::tick_rec_t             rec_q;
  logic [bdpc_pkg::EvCntW-1:0]     cnt_q, cnt_d;
  logic                            valid_q, valid_d;
  logic [IdxW-1:0]                 idx_q;
  logic [1:0]                      kind_q;
  logic [NumButtons-1:0]           mask_q;
  logic                            last_q;

  logic                            emit;
  logic                            last;
  logic [bdpc_pkg::SlotW-1:0]      sel;
  logic [bdpc_pkg::NumSlots-1:0]   rest;

  // Lowest pending slot
  always_comb begin
    sel = '0;
    for (int j = bdpc_pkg::NumSlots - 1; j >= 0; j--) begin
      if (pend_q[j]) begin
        sel = bdpc_pkg::SlotW'(j);
      end
    end
    rest      = pend_q;
    rest[sel] = 1'b0;
  end

  assign pop_o = !busy_q && !empty_i;
  assign emit  = busy_q && (!valid_q || ready_i);
  assign last  = (rest == '0) || (cnt_q == bdpc_pkg::EvCntW'(bdpc_pkg::MaxEvents - 1));

  // Drain control
  always_comb begin
    busy_d  = busy_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      pend_d = rec_i.pend;
      cnt_d  = '0;
    end else if (emit) begin
      valid_d = 1'b1;
      pend_d  = rest;
      cnt_d   = cnt_q + bdpc_pkg::EvCntW'(1);
      busy_d  = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pend_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
    if (emit) begin
      idx_q  <= sel[IdxW:1];
      kind_q <= rec_q.kind[sel];
      mask_q <= rec_q.mask[NumButtons-1:0];
      last_q <= last;
    end
  end

  assign valid_o        = valid_q;
  assign button_index_o = idx_q;
  assign event_kind_o   = kind_q;
  assign pressed_mask_o = mask_q;
  assign last_event_o   = last_q;

  `ASSERT_NEVER(a_busy_has_work, clk_i, rst_ni, busy_q && (pend_q == '0), "drain busy with no pending event")
  `ASSERT_PROP(a_cap_ends_tick, clk_i, rst_ni, emit && (cnt_q == bdpc_pkg::EvCntW'(bdpc_pkg::MaxEvents - 1)) |=> !busy_q, "event cap did not end the tick")
  `ASSERT_PROP(a_valid_from_drain, clk_i, rst_ni, $rose(valid_q) |-> $past(busy_q), "result appeared without an active drain")
  `ASSERT_PROP(a_last_frees_drain, clk_i, rst_ni, emit && last |=> !busy_q && valid_q && last_q, "final event did not close the tick")

endmodule

>>> sv/button_debounce_press_classifier.sv
// Four-button (NUM_BUTTONS) debouncer and press classifier. Each input request is one
// millisecond tick of raw active-low pin levels; the front end updates every button's
// debounce state in the cycle the tick is accepted and queues the tick's events (up to
// two per button, at most eight per tick). The back end loads a queued tick record and
// drains it one event per cycle, unless the output stalls, into a registered output,
// taking no new record before the tick's final event; quiet ticks produce no result
// and are accepted every cycle while the two-entry tick queue has room. Results carry
// the button index and pressed mask in tdata, the event kind in tuser and the tick's
// final event in tlast. Configuration writes must only happen while the block is idle.
module button_debounce_press_classifier #(
  parameter int NUM_BUTTONS = bdpc_pkg::NumButtonsDef,
  parameter int IdxW        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  parameter int InW         = ((NUM_BUTTONS + 7) / 8) * 8,
  parameter int OutW        = ((IdxW + NUM_BUTTONS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // tick input
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [InW-1:0]                s_axis_tdata_i,   // pin_levels
  // event output
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [OutW-1:0]               m_axis_tdata_o,   // button_index, pressed_mask
  output logic [1:0]                    m_axis_tuser_o,   // event_kind
  output logic                          m_axis_tlast_o    // last_event
);

  logic [bdpc_pkg::DebW-1:0]  debounce_q;
  logic [bdpc_pkg::LongW-1:0] long_press_q;

  logic                       tick;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       empty;
  bdpc_pkg::tick_rec_t        rec_in;
  bdpc_pkg::tick_rec_t        rec_out;
  logic [IdxW-1:0]            button_index;
  logic [NUM_BUTTONS-1:0]     pressed_mask;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdpc_pkg::DebounceRst;
      long_press_q <= bdpc_pkg::LongPressRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdpc_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[bdpc_pkg::DebW-1:0];
        bdpc_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata_i[bdpc_pkg::LongW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !full;
  assign tick            = s_axis_tvalid_i && !full;

  bdpc_front #(
    .NumButtons (NUM_BUTTONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .pin_levels_i (s_axis_tdata_i[NUM_BUTTONS-1:0]),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .push_o       (push),
    .rec_o        (rec_in)
  );

  bdpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  bdpc_back #(
    .NumButtons (NUM_BUTTONS),
    .IdxW       (IdxW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .rec_i          (rec_out),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid_o),
    .ready_i        (m_axis_tready_i),
    .button_index_o (button_index),
    .event_kind_o   (m_axis_tuser_o),
    .pressed_mask_o (pressed_mask),
    .last_event_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutW'({pressed_mask, button_index});

endmodule
